[sv/wsfp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and result type for the weather station frame parser.
package wsfp_pkg;

  // Frame marker characters
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_D    = 8'h44;

  // Result kinds
  localparam logic [1:0] KIND_LIVE     = 2'd0;
  localparam logic [1:0] KIND_DATE     = 2'd1;
  localparam logic [1:0] KIND_LOGGED   = 2'd2;
  localparam logic [1:0] KIND_TIME_REQ = 2'd3;

  // Capture store depth and index width
  localparam int CAP_DEPTH = 7;
  localparam int CAP_AW    = 3;

  // One result item, last field in the lowest bits
  typedef struct packed {
    logic [7:0]  second_value;
    logic [7:0]  minute_value;
    logic [7:0]  hour_value;
    logic [7:0]  day_value;
    logic [7:0]  month_value;
    logic [15:0] year_value;
    logic [7:0]  humidity_percent;
    logic [23:0] pressure_hundredths;
    logic [15:0] temperature_tenths;
    logic [1:0]  record_kind;
  } result_t;

endpackage

[sv/weather_station_frame_parser_unit.sv]
`timescale 1ns / 1ps
// Weather station frame parser: one received byte per item in, decoded records out.
// Each byte is parsed by a single state register step as it is taken; a record
// that completes on that byte is written the same edge to the output register, or
// to the skid stage when the output still holds one. One skid stage backs the output
// register, so bytes keep flowing while a record waits; the input stalls only when
// both hold records.
module weather_station_frame_parser_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [15:0] temperature_tenths, [39:16] pressure_hundredths,
                                  // [47:40] humidity_percent, [63:48] year_value,
                                  // [71:64] month_value, [79:72] day_value,
                                  // [87:80] hour_value, [95:88] minute_value,
                                  // [103:96] second_value
  output logic [1:0]   m_tuser    // [1:0] record_kind
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_WAIT_R  = 4'd1,
    ST_LIVE    = 4'd2,
    ST_WAIT_AT = 4'd3,
    ST_LEN     = 4'd4,
    ST_WAIT_K  = 4'd5,
    ST_DATE    = 4'd6,
    ST_WAIT_D  = 4'd7,
    ST_LOG     = 4'd8,
    ST_TIME1   = 4'd9,
    ST_TIME2   = 4'd10
  } state_t;

  state_t                        state, state_next;
  logic [wsfp_pkg::CAP_AW-1:0]   byte_count, byte_count_next;
  logic [7:0]                    capture [wsfp_pkg::CAP_DEPTH];
  logic                          cap_we;
  logic                          res_valid;
  wsfp_pkg::result_t             res;

  logic                          out_valid, skid_valid;
  wsfp_pkg::result_t             out_data, skid_data;
  logic                          in_take;
  logic                          out_take;
  logic [7:0]                    b;

  assign b        = s_tdata;
  assign s_tready = !skid_valid;
  assign in_take  = s_tvalid && s_tready;
  assign out_take = out_valid && m_tready;

  // Parser step for the current byte
  always_comb begin
    state_next      = state;
    byte_count_next = byte_count;
    cap_we          = 1'b0;
    res_valid       = 1'b0;
    res             = '0;
    unique case (state)
      ST_WAIT_R:  state_next = (b == wsfp_pkg::CH_R)  ? ST_LIVE  : ST_IDLE;
      ST_WAIT_AT: state_next = (b == wsfp_pkg::CH_AT) ? ST_LEN   : ST_IDLE;
      ST_TIME1:   state_next = (b == wsfp_pkg::CH_PCT) ? ST_TIME2 : ST_IDLE;
      ST_WAIT_K:  state_next = (b == wsfp_pkg::CH_K)  ? ST_DATE  : ST_IDLE;
      ST_WAIT_D:  state_next = (b == wsfp_pkg::CH_D)  ? ST_LOG   : ST_IDLE;
      ST_TIME2: begin
        if (b == wsfp_pkg::CH_F) begin
          res_valid       = 1'b1;
          res.record_kind = wsfp_pkg::KIND_TIME_REQ;
        end
        state_next = ST_IDLE;
      end
      // length word: counted, not kept
      ST_LEN: begin
        if (byte_count == 3'd1) begin
          byte_count_next = '0;
          state_next      = ST_WAIT_K;
        end else begin
          byte_count_next = byte_count + 3'd1;
        end
      end
      ST_DATE: begin
        cap_we = 1'b1;
        if (byte_count == 3'd6) begin
          res_valid          = 1'b1;
          res.record_kind    = wsfp_pkg::KIND_DATE;
          res.year_value     = {capture[0], capture[1]};
          res.month_value    = capture[2];
          res.day_value      = capture[3];
          res.hour_value     = capture[4];
          res.minute_value   = capture[5];
          res.second_value   = b;
          byte_count_next    = '0;
          state_next         = ST_WAIT_D;
        end else begin
          byte_count_next = byte_count + 3'd1;
        end
      end
      ST_LOG: begin
        cap_we = 1'b1;
        if (byte_count == 3'd5) begin
          res_valid               = 1'b1;
          res.record_kind         = wsfp_pkg::KIND_LOGGED;
          res.temperature_tenths  = {capture[0], capture[1]};
          res.humidity_percent    = capture[2];
          res.pressure_hundredths = {capture[3], capture[4], b};
          byte_count_next         = '0;
          state_next              = ST_WAIT_K;
        end else begin
          byte_count_next = byte_count + 3'd1;
        end
      end
      ST_LIVE: begin
        cap_we = 1'b1;
        if (byte_count == 3'd5) begin
          res_valid               = 1'b1;
          res.record_kind         = wsfp_pkg::KIND_LIVE;
          res.temperature_tenths  = {capture[0], capture[1]};
          res.pressure_hundredths = {capture[2], capture[3], capture[4]};
          res.humidity_percent    = b;
          byte_count_next         = '0;
          state_next              = ST_IDLE;
        end else begin
          byte_count_next = byte_count + 3'd1;
        end
      end
      // idle and unused codes: look for a frame start
      default: begin
        if (b == wsfp_pkg::CH_P)         state_next = ST_WAIT_R;
        else if (b == wsfp_pkg::CH_HASH) state_next = ST_WAIT_AT;
        else if (b == wsfp_pkg::CH_AMP)  state_next = ST_TIME1;
        else                             state_next = ST_IDLE;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      byte_count <= '0;
    end else if (in_take) begin
      state      <= state_next;
      byte_count <= byte_count_next;
    end
  end

  // Payload capture store
  always_ff @(posedge clk) begin
    if (in_take && cap_we) begin
      capture[byte_count] <= b;
    end
  end

  // Output register with one skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (in_take && res_valid) begin
        if (!out_valid || out_take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_data <= skid_data;
    end else if (in_take && res_valid) begin
      if (!out_valid || out_take) out_data  <= res;
      else                        skid_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_data.record_kind;
  assign m_tdata  = out_data[105:2];

endmodule
